>>> rtl/core/fpsq_pkg.sv
// ----------------------------------------------------------------------------
// fpsq_pkg
// Shared types and constants for the Q16.16 square root block: operand and
// result widths, start bits of the two digit passes, controller states and
// the command and status groups between controller and datapath.
// ----------------------------------------------------------------------------
package fpsq_pkg;

  // Payload widths
  localparam int unsigned ValueWidth = 32;
  localparam int unsigned RootWidth  = 25;

  // Fixed-point format
  localparam int unsigned FracBits = 16;

  // Working register constants
  localparam logic [ValueWidth-1:0] HighPartMask  = 32'hFFF0_0000;
  localparam logic [ValueWidth-1:0] StartBitLarge = ValueWidth'(1) << 30;
  localparam logic [ValueWidth-1:0] StartBitSmall = ValueWidth'(1) << 18;
  localparam logic [ValueWidth-1:0] FracMask      = (ValueWidth'(1) << FracBits) - 1;
  localparam logic [ValueWidth-1:0] FracHalf      = ValueWidth'(1) << (FracBits - 1);
  localparam logic [ValueWidth-1:0] FracStartBit  = ValueWidth'(1) << (FracBits - 2);

  // Controller states
  typedef enum logic [2:0] {
    ST_IDLE,
    ST_PASS1,
    ST_FIX,
    ST_PASS2,
    ST_ROUND,
    ST_OUT
  } state_e;

  // Commands from controller to datapath
  typedef struct packed {
    logic load;     // take a new operand
    logic step;     // one restoring digit step
    logic fix;      // half-step correction between passes
    logic round;    // final round-up of the last bit
    logic capture;  // write the signed result to the output register
  } cmd_t;

  // Status from datapath to controller
  typedef struct packed {
    logic last_step;  // current trial bit is the lowest one
  } status_t;

endpackage

>>> rtl/core/fpsq_datapath.sv
// ----------------------------------------------------------------------------
// fpsq_datapath
// Remainder, partial root and trial bit registers of the restoring square
// root, the correction and rounding steps and the signed output register.
// ----------------------------------------------------------------------------
module fpsq_datapath (
  input  logic                                   clk_i,
  input  logic [fpsq_pkg::ValueWidth-1:0]        value_i,
  input  fpsq_pkg::cmd_t                         cmd_i,
  output fpsq_pkg::status_t                      status_o,
  output logic signed [fpsq_pkg::RootWidth-1:0]  root_o
);

  localparam int unsigned W = fpsq_pkg::ValueWidth;

  logic [W-1:0] rem_q, rem_d;
  logic [W-1:0] acc_q, acc_d;
  logic [W-1:0] bit_q, bit_d;
  logic         neg_q, neg_d;
  logic signed [fpsq_pkg::RootWidth-1:0] root_q, root_d;

  logic [W-1:0] mag;
  logic [W-1:0] trial;
  logic [W-1:0] rem_diff;
  logic [W-1:0] acc_neg;

  // Operand magnitude; the most negative value wraps to 2^31
  assign mag      = value_i[W-1] ? (~value_i + W'(1)) : value_i;
  assign trial    = acc_q + bit_q;
  assign rem_diff = rem_q - acc_q;
  assign acc_neg  = ~acc_q + W'(1);

  // Next values of the working registers
  always_comb begin
    rem_d  = rem_q;
    acc_d  = acc_q;
    bit_d  = bit_q;
    neg_d  = neg_q;
    root_d = root_q;
    if (cmd_i.load) begin
      rem_d = mag;
      acc_d = '0;
      neg_d = value_i[W-1];
      // Starting above the top set pair only adds steps that keep acc at zero
      bit_d = ((mag & fpsq_pkg::HighPartMask) != '0) ? fpsq_pkg::StartBitLarge
                                                     : fpsq_pkg::StartBitSmall;
    end else if (cmd_i.step) begin
      if (rem_q >= trial) begin
        rem_d = rem_q - trial;
        acc_d = (acc_q >> 1) + bit_q;
      end else begin
        acc_d = acc_q >> 1;
      end
      bit_d = bit_q >> 2;
    end else if (cmd_i.fix) begin
      if (rem_q > fpsq_pkg::FracMask) begin
        rem_d = (rem_diff << fpsq_pkg::FracBits) - fpsq_pkg::FracHalf;
        acc_d = (acc_q << fpsq_pkg::FracBits) + fpsq_pkg::FracHalf;
      end else begin
        rem_d = rem_q << fpsq_pkg::FracBits;
        acc_d = acc_q << fpsq_pkg::FracBits;
      end
      bit_d = fpsq_pkg::FracStartBit;
    end else if (cmd_i.round) begin
      acc_d = acc_q + W'(rem_q > acc_q);
    end
    if (cmd_i.capture) begin
      root_d = neg_q ? acc_neg[fpsq_pkg::RootWidth-1:0]
                     : acc_q[fpsq_pkg::RootWidth-1:0];
    end
  end

  // Payload registers, no reset needed
  always_ff @(posedge clk_i) begin
    rem_q  <= rem_d;
    acc_q  <= acc_d;
    bit_q  <= bit_d;
    neg_q  <= neg_d;
    root_q <= root_d;
  end

  assign status_o.last_step = bit_q[0];
  assign root_o             = root_q;

endmodule

>>> rtl/core/fpsq_ctrl.sv
// ----------------------------------------------------------------------------
// fpsq_ctrl
// Sequencer for the square root: walks integer pass, correction, fraction
// pass and rounding, and owns both handshakes and the output valid flag.
// ----------------------------------------------------------------------------
module fpsq_ctrl (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_ready_o,
  output logic                out_valid_o,
  input  logic                out_ready_i,
  input  fpsq_pkg::status_t   status_i,
  output fpsq_pkg::cmd_t      cmd_o,
  output fpsq_pkg::state_e    state_o
);

  fpsq_pkg::state_e state_q, state_d;
  logic             out_valid_q, out_valid_d;
  logic             out_free;

  // Output register can take a result this cycle
  assign out_free = !out_valid_q || out_ready_i;

  // Next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      fpsq_pkg::ST_IDLE:  if (in_valid_i) state_d = fpsq_pkg::ST_PASS1;
      fpsq_pkg::ST_PASS1: if (status_i.last_step) state_d = fpsq_pkg::ST_FIX;
      fpsq_pkg::ST_FIX:   state_d = fpsq_pkg::ST_PASS2;
      fpsq_pkg::ST_PASS2: if (status_i.last_step) state_d = fpsq_pkg::ST_ROUND;
      fpsq_pkg::ST_ROUND: state_d = fpsq_pkg::ST_OUT;
      fpsq_pkg::ST_OUT:   if (out_free) state_d = fpsq_pkg::ST_IDLE;
      default:            state_d = fpsq_pkg::ST_IDLE;
    endcase
  end

  // Commands and handshake outputs
  always_comb begin
    cmd_o      = '0;
    in_ready_o = 1'b0;
    unique case (state_q)
      fpsq_pkg::ST_IDLE: begin
        in_ready_o = 1'b1;
        cmd_o.load = in_valid_i;
      end
      fpsq_pkg::ST_PASS1: cmd_o.step  = 1'b1;
      fpsq_pkg::ST_FIX:   cmd_o.fix   = 1'b1;
      fpsq_pkg::ST_PASS2: cmd_o.step  = 1'b1;
      fpsq_pkg::ST_ROUND: cmd_o.round = 1'b1;
      fpsq_pkg::ST_OUT:   cmd_o.capture = out_free;
      default: ;
    endcase
  end

  // Output valid flag
  always_comb begin
    out_valid_d = out_valid_q;
    if (cmd_o.capture) begin
      out_valid_d = 1'b1;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= fpsq_pkg::ST_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  assign out_valid_o = out_valid_q;
  assign state_o     = state_q;

endmodule

>>> rtl/core/fixed_point_square_root.sv
// ----------------------------------------------------------------------------
// fixed_point_square_root
// Signed Q16.16 square root, digit by digit, one result bit per cycle.
//
// Input channel: value_i with in_valid_i / in_ready_o; a beat is taken while
// the block is idle. Output channel: root_o with out_valid_o / out_ready_i,
// held in an output register.
// Operands below 2^20 in magnitude start the integer pass at a lower trial
// bit. Restoring recurrence: one shared subtract/compare step per result
// bit, 10 or 16 integer steps, one correction, 8 fraction steps, one
// rounding step and the capture into the output register.
// One operand is in flight at a time; a new beat is taken as soon as the
// result sits in the output register, even while the receiver stalls.
// A stalled receiver holds the result; a finished root waits in its last
// state until the output register frees up.
// Negative operands give the negated root of the magnitude.
// Reset clears the sequencer and the output valid flag.
// ----------------------------------------------------------------------------
module fixed_point_square_root (
  input  logic                                   clk_i,
  input  logic                                   rst_ni,
  input  logic                                   in_valid_i,
  output logic                                   in_ready_o,
  input  logic signed [fpsq_pkg::ValueWidth-1:0] value_i,
  output logic                                   out_valid_o,
  input  logic                                   out_ready_i,
  output logic signed [fpsq_pkg::RootWidth-1:0]  root_o
);

  fpsq_pkg::cmd_t    cmd;
  fpsq_pkg::status_t status;
  fpsq_pkg::state_e  state;

  fpsq_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .status_i    (status),
    .cmd_o       (cmd),
    .state_o     (state)
  );

  fpsq_datapath u_datapath (
    .clk_i    (clk_i),
    .value_i  (value_i),
    .cmd_i    (cmd),
    .status_o (status),
    .root_o   (root_o)
  );

`ifndef ASSERT_OFF
  // Accepted beat makes the block busy
  a_busy_after_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o |=> !in_ready_o)
    else $error("input ready while an operand is in flight");

  // Fraction pass is only entered through the correction step
  a_fix_before_pass2: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state == fpsq_pkg::ST_PASS2) && ($past(state) != fpsq_pkg::ST_PASS2)
    |-> $past(state) == fpsq_pkg::ST_FIX)
    else $error("fraction pass entered without correction");

  // A new result only appears from the capture state
  a_valid_from_capture: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_o) |-> $past(state) == fpsq_pkg::ST_OUT)
    else $error("output valid raised outside capture");

  // Root stays within the range of the square root of 2^15
  a_root_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (root_o <= 25'sd11863284) && (root_o >= -25'sd11863284))
    else $error("root out of range");
`endif

endmodule

>>> dv/fixed_point_square_root_tb.sv
// ----------------------------------------------------------------------------
// fixed_point_square_root_tb
// Self-checking bench for the Q16.16 square root block. Operands go in from a
// queue through a valve-style driver; each accepted beat is predicted by a
// bit-exact restoring root model and checked in order against the output
// beats. Both sides idle in random bursts, the receiver holds off once for a
// long stretch, and the sender drains the block fully between phases.
// ----------------------------------------------------------------------------
module fixed_point_square_root_tb;

  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned ValueWidth = fpsq_pkg::ValueWidth;
  localparam int unsigned RootWidth  = fpsq_pkg::RootWidth;

  // Working constants of the digit recurrence
  localparam logic [31:0] UpperBits    = 32'hFFF0_0000;
  localparam logic [31:0] WideStart    = 32'h4000_0000;
  localparam logic [31:0] NarrowStart  = 32'h0004_0000;
  localparam logic [31:0] FractionMask = 32'h0000_FFFF;
  localparam logic [31:0] HalfStep     = 32'h0000_8000;
  localparam logic [31:0] FracStart    = 32'h0000_4000;
  localparam int unsigned FracShift    = 16;

  localparam int unsigned HoldOffCycles = 400;
  localparam int unsigned DrainCycles   = 40;

  typedef struct packed {
    logic [ValueWidth-1:0] operand;
    logic [RootWidth-1:0]  root;
  } root_expect_t;

  logic                         clk_i       = 1'b0;
  logic                         rst_ni      = 1'b0;
  logic                         in_valid_i  = 1'b0;
  logic                         in_ready_o;
  logic signed [ValueWidth-1:0] value_i     = '0;
  logic                         out_valid_o;
  logic                         out_ready_i = 1'b0;
  logic signed [RootWidth-1:0]  root_o;

  logic [ValueWidth-1:0] pending_operands[$];
  root_expect_t          expected_roots[$];

  logic        in_taken  = 1'b0;
  logic        hold_off  = 1'b0;
  logic        quiet     = 1'b0;
  int unsigned send_gap  = 0;
  int unsigned stall_gap = 0;
  int unsigned beats_in  = 0;
  int unsigned fail_count = 0;

  fixed_point_square_root DUT (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .value_i     (value_i),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .root_o      (root_o)
  );

  // Clock
  initial begin
    forever #1 clk_i = ~clk_i;
  end

  // Restoring square root of |operand|, integer pass then fraction pass, negated for negative operands
  function automatic logic [RootWidth-1:0] q16_sqrt(logic [ValueWidth-1:0] operand);
    logic [31:0] rem;
    logic [31:0] acc;
    logic [31:0] trial;
    logic [31:0] trial_bit;
    logic [31:0] signed_root;
    rem = operand[31] ? 32'd0 - operand : operand;
    acc = '0;
    trial_bit = ((rem & UpperBits) != 0) ? WideStart : NarrowStart;
    while (trial_bit > rem) trial_bit >>= 2;
    for (int pass = 0; pass < 2; pass++) begin
      while (trial_bit != 0) begin
        trial = acc + trial_bit;
        if (rem >= trial) begin
          rem -= trial;
          acc = (acc >> 1) + trial_bit;
        end else begin
          acc >>= 1;
        end
        trial_bit >>= 2;
      end
      // half-step correction into the fraction pass
      if (pass == 0) begin
        if (rem > FractionMask) begin
          rem = ((rem - acc) << FracShift) - HalfStep;
          acc = (acc << FracShift) + HalfStep;
        end else begin
          rem <<= FracShift;
          acc <<= FracShift;
        end
        trial_bit = FracStart;
      end
    end
    if (rem > acc) acc++;
    signed_root = operand[31] ? 32'd0 - acc : acc;
    return signed_root[RootWidth-1:0];
  endfunction

  // Random operand, biased towards squares, small values and pass boundaries
  function automatic logic [ValueWidth-1:0] random_operand();
    logic [31:0] raw;
    int unsigned q;
    case ($urandom_range(0, 5))
      0: raw = $urandom;
      1: raw = $urandom_range(0, 32'h000F_FFFF);
      2: begin
        q   = $urandom_range(0, 46340);
        raw = q * q;
      end
      3: raw = 32'h000F_FF00 + $urandom_range(0, 511);
      4: raw = $urandom_range(0, 255);
      default: raw = $urandom | 32'h8000_0000;
    endcase
    if ($urandom_range(0, 2) == 0) raw = 32'd0 - raw;
    return raw;
  endfunction

  task automatic note_failure(string msg);
    if (fail_count < 10) $display("%s", msg);
    fail_count++;
  endtask

  // Sender: keep the beat until taken, then idle or offer the next operand
  always @(negedge clk_i) begin : drive_operands
    logic                  next_valid;
    logic [ValueWidth-1:0] next_value;
    next_valid = in_valid_i;
    next_value = value_i;
    if (rst_ni && (!in_valid_i || in_taken)) begin
      next_valid = 1'b0;
      if (send_gap != 0) begin
        send_gap <= send_gap - 1;
      end else if (pending_operands.size() != 0) begin
        if (!quiet && $urandom_range(0, 7) == 0) begin
          send_gap <= $urandom_range(0, 15);
        end else begin
          next_valid = 1'b1;
          next_value = pending_operands.pop_front();
        end
      end
    end
    in_valid_i <= next_valid;
    value_i    <= next_value;
  end

  // Receiver: stall bursts plus the long hold-off
  always @(negedge clk_i) begin : drive_ready
    logic next_ready;
    next_ready = 1'b1;
    if (stall_gap != 0) begin
      next_ready = 1'b0;
      stall_gap <= stall_gap - 1;
    end else if (!quiet && $urandom_range(0, 7) == 0) begin
      next_ready = 1'b0;
      stall_gap <= $urandom_range(0, 15);
    end
    out_ready_i <= rst_ni && next_ready && !hold_off;
  end

  // Check output beats in order, then log new input beats
  always @(posedge clk_i) begin : score_roots
    root_expect_t head;
    if (rst_ni) begin
      if (out_valid_o && out_ready_i) begin
        if (expected_roots.size() == 0) begin
          note_failure($sformatf("unexpected output beat: root %0d", root_o));
        end else begin
          head = expected_roots.pop_front();
          if (root_o !== head.root) begin
            note_failure($sformatf("root mismatch for operand 0x%08h: expected %0d, got %0d",
                                   head.operand, $signed(head.root), root_o));
          end
        end
      end
      if (in_valid_i && in_ready_o) begin
        expected_roots.push_back('{operand: value_i, root: q16_sqrt(value_i)});
        beats_in <= beats_in + 1;
      end
      in_taken <= in_valid_i && in_ready_o;
    end
  end

  // Long receiver hold-off once the traffic is flowing
  initial begin
    while (beats_in < 60) @(posedge clk_i);
    hold_off = 1'b1;
    repeat (HoldOffCycles) @(posedge clk_i);
    hold_off = 1'b0;
  end

  // Waits until the block is empty and nothing is outstanding
  task automatic wait_drained();
    do @(negedge clk_i);
    while (pending_operands.size() != 0 || in_valid_i || expected_roots.size() != 0);
    @(posedge clk_i);
  endtask

  // Stimulus phases
  initial begin
    repeat (11) @(posedge clk_i);
    @(negedge clk_i) rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed: zero, extremes, signs, pass boundaries, exact squares
    pending_operands = '{32'h0000_0000, 32'h0000_0001, 32'hFFFF_FFFF, 32'h7FFF_FFFF,
                         32'h8000_0000, 32'h8000_0001, 32'h0001_0000, 32'h0004_0000,
                         32'hFFFF_0000, 32'h000F_FFFF, 32'h0010_0000, 32'hFFF0_0000,
                         32'h0000_FFFF, 32'h0001_0001, 32'h0002_4000, 32'h4000_0000,
                         32'h3FFF_FFFF, 32'h0000_0002, 32'hFFFF_FFFE, 32'h5555_5555,
                         32'hAAAA_AAAA};
    wait_drained();

    // Random with idling; the long hold-off lands in here
    repeat (200) pending_operands.push_back(random_operand());
    wait_drained();

    // Random with idling, last stretch without any
    repeat (250) pending_operands.push_back(random_operand());
    while (pending_operands.size() > 80) @(posedge clk_i);
    quiet = 1'b1;
    wait_drained();

    repeat (DrainCycles) @(posedge clk_i);
    if (fail_count == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

  // Watchdog
  initial begin
    #400000;
    $display("FAIL");
    $finish;
  end

endmodule
